FILE: design/cbs_pkg.sv
// Shared types, widths and codes for the cubic B-spline curve evaluator.
`timescale 1ns / 1ps
package cbs_pkg;

	localparam int MAX_POINTS_DEF = 64;
	localparam int COORD_W = 32;
	localparam int T_W     = 18;
	localparam int OP_W    = 2;
	localparam int U_W     = 17;
	localparam int WGT_W   = 16;
	localparam int PROD_W  = COORD_W + WGT_W + 1;

	localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
	localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
	localparam logic [OP_W-1:0] OP_EVAL   = 2'd2;

	localparam logic [U_W-1:0] ONE_Q16 = 17'h10000;

	// ceil(2^19 / 3), exact floor division by three for operands below 2^19
	localparam logic [17:0] RECIP3 = 18'd174763;
	localparam int RECIP3_SH = 19;

	typedef struct packed {
		logic signed [COORD_W-1:0] z;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] x;
	} point_t;

	typedef struct packed {
		logic signed [PROD_W-1:0] z;
		logic signed [PROD_W-1:0] y;
		logic signed [PROD_W-1:0] x;
	} prod_t;

endpackage

FILE: design/cubic_bspline_curve_eval_core.sv
// Top level of the uniform cubic B-spline curve evaluator.
//
// Input channel (in_valid/in_ready) carries one operation per transaction:
// clear, append a control point, or evaluate the curve at t_param. Output
// channel (out_valid/out_ready) returns one result per input transaction,
// in order: accepted flag plus out_x/out_y/out_z (zero unless an evaluate
// succeeded).
// Clear and append: the result goes through ST_FIN into the output register.
// Evaluate: the four control points come out of the single read port of
// the point RAM one per cycle while the weight pipeline runs, then four
// lanes multiply and a merge stage sums, rounds and saturates.
// One item is in flight at a time; in_ready is high while the core is idle.
// A finished result waits in an internal register while the output register
// is stalled; the core takes no new item until it has moved on.
// Reset empties the point count and the output register; the point RAM is
// not cleared, entries are only read after an append wrote them.
`timescale 1ns / 1ps
module cubic_bspline_curve_eval_core #(
	parameter int MAX_POINTS = cbs_pkg::MAX_POINTS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [cbs_pkg::OP_W-1:0]           operation,
	input  logic signed [cbs_pkg::COORD_W-1:0] point_x,
	input  logic signed [cbs_pkg::COORD_W-1:0] point_y,
	input  logic signed [cbs_pkg::COORD_W-1:0] point_z,
	input  logic signed [cbs_pkg::T_W-1:0]     t_param,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               accepted,
	output logic signed [cbs_pkg::COORD_W-1:0] out_x,
	output logic signed [cbs_pkg::COORD_W-1:0] out_y,
	output logic signed [cbs_pkg::COORD_W-1:0] out_z
);
	import cbs_pkg::*;

	localparam int CNT_W = $clog2(MAX_POINTS + 1);
	localparam int AW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int S_W   = U_W + CNT_W;
	localparam int PT_W  = $bits(point_t);

	typedef enum logic [2:0] {
		ST_IDLE, ST_SEG, ST_RD, ST_CAP, ST_MUL, ST_ADD, ST_SUM, ST_FIN
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] count_q;
	logic [1:0]       k_q;
	logic [1:0]       rd_idx_q;
	logic             rd_vld_q;
	logic             out_valid_q;
	logic             pend_acc_q;
	point_t           pend_q;
	logic             out_acc_q;
	point_t           out_q;

	logic [U_W-1:0]   t_q;
	logic [CNT_W-1:0] segs_q;
	logic [CNT_W-1:0] seg_q;
	logic [U_W-1:0]   u_q;
	point_t           pts_q [4];

	logic             in_fire;
	logic             not_full;
	logic             can_eval;
	logic             out_free;
	logic [U_W-1:0]   t_clamp;
	logic [S_W-1:0]   s_full;
	logic [CNT_W:0]   seg_hi;
	logic [CNT_W-1:0] seg_n;
	logic [U_W-1:0]   u_n;
	logic [CNT_W:0]   rsum;
	logic             ram_we;
	logic [AW-1:0]    ram_raddr;
	logic [PT_W-1:0]  ram_rdata;
	logic [WGT_W-1:0] wgt [4];
	prod_t            prods [4];
	point_t           merged;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign not_full  = count_q < CNT_W'(MAX_POINTS);
	assign can_eval  = count_q >= CNT_W'(4);
	assign out_free  = !out_valid_q || out_ready;
	assign ram_we    = in_fire && (operation == OP_APPEND) && not_full;
	assign rsum      = {1'b0, seg_q} + {{(CNT_W - 1){1'b0}}, k_q};
	assign ram_raddr = rsum[AW-1:0];

	assign out_valid = out_valid_q;
	assign accepted  = out_acc_q;
	assign out_x     = out_q.x;
	assign out_y     = out_q.y;
	assign out_z     = out_q.z;

	always_comb begin
		if (t_param[T_W-1]) begin
			t_clamp = '0;
		end else if (t_param > 18'sd65536) begin
			t_clamp = ONE_Q16;
		end else begin
			t_clamp = t_param[U_W-1:0];
		end
		s_full = S_W'(t_q) * S_W'(segs_q);
		seg_hi = s_full[S_W-1:16];
		if (seg_hi >= {1'b0, segs_q}) begin
			seg_n = segs_q - CNT_W'(1);
			u_n   = ONE_Q16;
		end else begin
			seg_n = seg_hi[CNT_W-1:0];
			u_n   = {1'b0, s_full[15:0]};
		end
	end

	cbs_ram #(
		.WIDTH(PT_W),
		.DEPTH(MAX_POINTS)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(count_q[AW-1:0]),
		.wdata({point_z, point_y, point_x}),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	cbs_weights u_weights (
		.clk (clk),
		.u   (u_q),
		.w_s4(wgt)
	);

	for (genvar i = 0; i < 4; i++) begin : g_lane
		cbs_lane u_lane (
			.clk   (clk),
			.weight(wgt[i]),
			.pt    (pts_q[i]),
			.prod  (prods[i])
		);
	end

	cbs_merge u_merge (
		.clk   (clk),
		.prods (prods),
		.result(merged)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			k_q         <= '0;
			rd_idx_q    <= '0;
			rd_vld_q    <= 1'b0;
			out_valid_q <= 1'b0;
			pend_acc_q  <= 1'b0;
			pend_q      <= '0;
			out_acc_q   <= 1'b0;
			out_q       <= '0;
		end else begin
			rd_vld_q <= (state_q == ST_RD);
			rd_idx_q <= k_q;
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						pend_q     <= '0;
						pend_acc_q <= 1'b0;
						state_q    <= ST_FIN;
						case (operation)
							OP_CLEAR: begin
								count_q    <= '0;
								pend_acc_q <= 1'b1;
							end
							OP_APPEND: begin
								if (not_full) begin
									count_q <= count_q + CNT_W'(1);
								end
								pend_acc_q <= not_full;
							end
							OP_EVAL: begin
								if (can_eval) begin
									state_q <= ST_SEG;
								end
							end
							default: begin
								pend_acc_q <= 1'b0;
							end
						endcase
					end
				end
				ST_SEG: begin
					k_q     <= '0;
					state_q <= ST_RD;
				end
				ST_RD: begin
					k_q <= k_q + 2'd1;
					if (k_q == 2'd3) begin
						state_q <= ST_CAP;
					end
				end
				ST_CAP: state_q <= ST_MUL;
				ST_MUL: state_q <= ST_ADD;
				ST_ADD: state_q <= ST_SUM;
				ST_SUM: begin
					pend_acc_q <= 1'b1;
					pend_q     <= merged;
					state_q    <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_acc_q   <= pend_acc_q;
						out_q       <= pend_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			t_q    <= t_clamp;
			segs_q <= count_q - CNT_W'(3);
		end
		if (state_q == ST_SEG) begin
			seg_q <= seg_n;
			u_q   <= u_n;
		end
		if (rd_vld_q) begin
			pts_q[rd_idx_q] <= point_t'(ram_rdata);
		end
	end

endmodule

FILE: design/cbs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module cbs_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: design/cbs_weights.sv
// Four-stage pipeline that forms the rounded Q16 B-spline basis weights from u.
`timescale 1ns / 1ps
module cbs_weights (
	input  logic                         clk,
	input  logic [cbs_pkg::U_W-1:0]      u,
	output logic [cbs_pkg::WGT_W-1:0]    w_s4 [4]
);
	import cbs_pkg::*;

	localparam int WW = 54;
	localparam logic signed [WW-1:0] ONE48 = 54'sd1 <<< 48;
	localparam logic signed [WW-1:0] HALF  = 54'sd3 <<< 32;

	logic [U_W-1:0]  u_s1, v_s1, u_s2;
	logic [32:0]     uu_s1, vv_s1, uu_s2;
	logic [48:0]     uuu_s2, vvv_s2;
	logic [17:0]     x_s3 [4];

	logic signed [WW-1:0] u3e, u2e, u1e;
	logic signed [WW-1:0] wt [4];
	logic signed [WW-1:0] ae [4];
	logic [35:0]          qp [4];

	always_ff @(posedge clk) begin
		u_s1   <= u;
		v_s1   <= ONE_Q16 - u;
		uu_s1  <= 33'(u) * 33'(u);
		vv_s1  <= 33'(ONE_Q16 - u) * 33'(ONE_Q16 - u);
		u_s2   <= u_s1;
		uu_s2  <= uu_s1;
		uuu_s2 <= 49'(uu_s1) * 49'(u_s1);
		vvv_s2 <= 49'(vv_s1) * 49'(v_s1);
	end

	always_comb begin
		u3e = $signed({5'b0, uuu_s2});
		u2e = $signed({21'b0, uu_s2}) <<< 16;
		u1e = $signed({37'b0, u_s2}) <<< 32;
		wt[0] = $signed({5'b0, vvv_s2});
		wt[1] = u3e + (u3e <<< 1) - ((u2e <<< 2) + (u2e <<< 1)) + (ONE48 <<< 2);
		wt[2] = (u2e + (u2e <<< 1)) + (u1e + (u1e <<< 1)) + ONE48
			- (u3e + (u3e <<< 1));
		wt[3] = u3e;
		for (int i = 0; i < 4; i++) begin
			ae[i] = wt[i] + HALF;
			qp[i] = x_s3[i] * RECIP3;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++) begin
			x_s3[i] <= ae[i][50:33];
			w_s4[i] <= qp[i][RECIP3_SH+WGT_W-1:RECIP3_SH];
		end
	end

endmodule

FILE: design/cbs_lane.sv
// One blend lane: weight times control point on all three axes, registered.
`timescale 1ns / 1ps
module cbs_lane (
	input  logic                      clk,
	input  logic [cbs_pkg::WGT_W-1:0] weight,
	input  cbs_pkg::point_t           pt,
	output cbs_pkg::prod_t            prod
);
	import cbs_pkg::*;

	logic signed [WGT_W:0] ws;

	assign ws = $signed({1'b0, weight});

	always_ff @(posedge clk) begin
		prod.x <= PROD_W'(ws) * PROD_W'(pt.x);
		prod.y <= PROD_W'(ws) * PROD_W'(pt.y);
		prod.z <= PROD_W'(ws) * PROD_W'(pt.z);
	end

endmodule

FILE: design/cbs_merge.sv
// Merge of the four lane products: registered pair sums, final sum, round, saturate.
`timescale 1ns / 1ps
module cbs_merge (
	input  logic            clk,
	input  cbs_pkg::prod_t  prods [4],
	output cbs_pkg::point_t result
);
	import cbs_pkg::*;

	localparam int PW = PROD_W + 1;
	localparam int AW = PROD_W + 2;

	logic signed [PW-1:0] px_s1 [2];
	logic signed [PW-1:0] py_s1 [2];
	logic signed [PW-1:0] pz_s1 [2];

	function automatic logic signed [COORD_W-1:0] round_sat(
		input logic signed [PW-1:0] a,
		input logic signed [PW-1:0] b
	);
		logic signed [AW-1:0] acc;
		logic signed [AW-1:0] r;
		acc = AW'(a) + AW'(b) + AW'(32768);
		r = acc >>> 16;
		if (r > $signed(AW'(32'sh7fffffff))) begin
			round_sat = 32'sh7fffffff;
		end else if (r < -$signed(AW'(33'sh080000000))) begin
			round_sat = 32'sh80000000;
		end else begin
			round_sat = r[COORD_W-1:0];
		end
	endfunction

	always_ff @(posedge clk) begin
		for (int i = 0; i < 2; i++) begin
			px_s1[i] <= PW'(prods[2*i].x) + PW'(prods[2*i+1].x);
			py_s1[i] <= PW'(prods[2*i].y) + PW'(prods[2*i+1].y);
			pz_s1[i] <= PW'(prods[2*i].z) + PW'(prods[2*i+1].z);
		end
	end

	always_comb begin
		result.x = round_sat(px_s1[0], px_s1[1]);
		result.y = round_sat(py_s1[0], py_s1[1]);
		result.z = round_sat(pz_s1[0], pz_s1[1]);
	end

endmodule

FILE: design/cbs_checker.sv
// Port-level checker for the curve evaluator, bound to the top level.
`timescale 1ns / 1ps
module cbs_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_ready,
	input logic [cbs_pkg::OP_W-1:0]           operation,
	input logic                               out_valid,
	input logic                               out_ready,
	input logic                               accepted,
	input logic signed [cbs_pkg::COORD_W-1:0] out_x,
	input logic signed [cbs_pkg::COORD_W-1:0] out_y,
	input logic signed [cbs_pkg::COORD_W-1:0] out_z
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(accepted)
			&& $stable(out_x) && $stable(out_y) && $stable(out_z))
		else $error("output changed while stalled");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !accepted |-> out_x == 0 && out_y == 0 && out_z == 0)
		else $error("rejected transaction carries a nonzero point");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second transaction taken while one is in flight");

	// with the output free, clear, append and unused codes reach out_valid via ST_FIN
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (operation != cbs_pkg::OP_EVAL)
			&& (!out_valid || out_ready) |=> ##1 out_valid)
		else $error("no result after transaction");

endmodule

bind cubic_bspline_curve_eval_core cbs_checker u_cbs_checker (.*);

FILE: dv/testbench.sv
// Self-checking testbench for the cubic B-spline curve evaluator core.
`timescale 1ns / 1ps
module testbench;
	import cbs_pkg::*;

	localparam int MAX_PTS = MAX_POINTS_DEF;
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7fffffff;
	localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh80000000;
	localparam longint WGT_DIV = longint'(6) <<< 32;
	localparam int STALL_LEN = 300;

	typedef struct packed {
		logic                      ok;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
	} curve_out_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [OP_W-1:0] operation;
	logic signed [COORD_W-1:0] point_x;
	logic signed [COORD_W-1:0] point_y;
	logic signed [COORD_W-1:0] point_z;
	logic signed [T_W-1:0] t_param;
	logic out_valid;
	logic out_ready;
	logic accepted;
	logic signed [COORD_W-1:0] out_x;
	logic signed [COORD_W-1:0] out_y;
	logic signed [COORD_W-1:0] out_z;

	point_t ctrl_pts[MAX_PTS];
	int n_pts;
	curve_out_t due_outputs[$];
	int mismatches;
	bit calm;
	bit stall_req;

	cubic_bspline_curve_eval_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.point_x(point_x),
		.point_y(point_y),
		.point_z(point_z),
		.t_param(t_param),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.accepted(accepted),
		.out_x(out_x),
		.out_y(out_y),
		.out_z(out_z)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("== FAIL ==");
		$finish;
	end

	function automatic longint round_q16(input longint w48);
		return (w48 + WGT_DIV / 2) / WGT_DIV;
	endfunction

	function automatic logic signed [COORD_W-1:0] blend_q16(input longint w[4],
			input longint p[4]);
		longint acc;
		longint r;
		acc = 0;
		for (int i = 0; i < 4; i++)
			acc += w[i] * p[i];
		r = (acc + 32768) >>> 16;
		if (r > longint'(COORD_MAX))
			r = longint'(COORD_MAX);
		if (r < longint'(COORD_MIN))
			r = longint'(COORD_MIN);
		return r[COORD_W-1:0];
	endfunction

	task automatic apply_curve_op(input logic [OP_W-1:0] op, input logic signed [COORD_W-1:0] px,
			input logic signed [COORD_W-1:0] py, input logic signed [COORD_W-1:0] pz,
			input logic signed [T_W-1:0] t);
		curve_out_t r;
		longint tc, segs, s, seg, u, u2, u3, om;
		longint w[4];
		longint cx[4], cy[4], cz[4];
		r = '0;
		case (op)
			OP_CLEAR: begin
				n_pts = 0;
				r.ok = 1'b1;
			end
			OP_APPEND: begin
				if (n_pts < MAX_PTS) begin
					ctrl_pts[n_pts].x = px;
					ctrl_pts[n_pts].y = py;
					ctrl_pts[n_pts].z = pz;
					n_pts++;
					r.ok = 1'b1;
				end
			end
			OP_EVAL: begin
				if (n_pts >= 4) begin
					tc = t;
					if (tc < 0)
						tc = 0;
					if (tc > 65536)
						tc = 65536;
					segs = n_pts - 3;
					s = tc * segs;
					seg = s >>> 16;
					if (seg >= segs)
						seg = segs - 1;
					u = s - seg * 65536;
					u2 = u * u;
					u3 = u2 * u;
					om = 65536 - u;
					w[0] = round_q16(om * om * om);
					w[1] = round_q16(3 * u3 - 6 * (u2 <<< 16) + (longint'(4) <<< 48));
					w[2] = round_q16(-3 * u3 + 3 * (u2 <<< 16) + 3 * (u <<< 32)
						+ (longint'(1) <<< 48));
					w[3] = round_q16(u3);
					for (int i = 0; i < 4; i++) begin
						cx[i] = ctrl_pts[seg + i].x;
						cy[i] = ctrl_pts[seg + i].y;
						cz[i] = ctrl_pts[seg + i].z;
					end
					r.ok = 1'b1;
					r.x = blend_q16(w, cx);
					r.y = blend_q16(w, cy);
					r.z = blend_q16(w, cz);
				end
			end
			default: ;
		endcase
		due_outputs.push_back(r);
	endtask

	task automatic report_mismatch(input string msg);
		if (mismatches < 40)
			$display("MISMATCH at %0t: %s", $time, msg);
		mismatches++;
	endtask

	// one transaction on the input channel; returns at the accepting edge
	task automatic send_op(input logic [OP_W-1:0] op, input logic signed [COORD_W-1:0] px,
			input logic signed [COORD_W-1:0] py, input logic signed [COORD_W-1:0] pz,
			input logic signed [T_W-1:0] t);
		int gap;
		gap = 0;
		if (!calm && $urandom_range(99) < 8)
			gap = $urandom_range(1, 5);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		point_x <= px;
		point_y <= py;
		point_z <= pz;
		t_param <= t;
		do @(posedge clk); while (!in_ready);
		apply_curve_op(op, px, py, pz, t);
	endtask

	function automatic logic signed [COORD_W-1:0] rand_coord();
		case ($urandom_range(9))
			0: return COORD_MAX;
			1: return COORD_MIN;
			2, 3: return int'($urandom_range(2097151)) - 1048576;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic signed [T_W-1:0] rand_t();
		case ($urandom_range(9))
			0: return 18'sd0;
			1: return 18'sd65536;
			2, 3: return T_W'($urandom);
			default: return T_W'($urandom_range(65536));
		endcase
	endfunction

	// receiver: random stalls, calm stretches, and one long hold-off on request
	initial begin
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (stall_req) begin
				stall_req = 1'b0;
				out_ready <= 1'b0;
				repeat (STALL_LEN - 1) @(posedge clk);
			end else if (calm) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= ($urandom_range(99) >= 8);
			end
		end
	end

	always @(posedge clk) begin
		curve_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (due_outputs.size() == 0) begin
				report_mismatch("result transaction with nothing pending");
			end else begin
				want = due_outputs.pop_front();
				if (accepted !== want.ok)
					report_mismatch($sformatf("accepted %b, want %b", accepted, want.ok));
				if (out_x !== want.x)
					report_mismatch($sformatf("out_x %0d, want %0d", out_x, want.x));
				if (out_y !== want.y)
					report_mismatch($sformatf("out_y %0d, want %0d", out_y, want.y));
				if (out_z !== want.z)
					report_mismatch($sformatf("out_z %0d, want %0d", out_z, want.z));
			end
		end
	end

	// rejections: evaluate on an empty or short store, the unused opcode
	task automatic test_empty_store();
		send_op(OP_CLEAR, 0, 0, 0, 0);
		send_op(OP_EVAL, 0, 0, 0, 18'sd0);
		send_op(OP_UNUSED, COORD_MAX, COORD_MIN, -1, -18'sd1);
		send_op(OP_APPEND, COORD_MAX, COORD_MIN, 0, 0);
		send_op(OP_APPEND, COORD_MIN, COORD_MAX, 1, 0);
		send_op(OP_APPEND, 0, -1, COORD_MAX, 0);
		send_op(OP_EVAL, 0, 0, 0, 18'sd32768);
	endtask

	// one segment; t clamped below zero and above one
	task automatic test_single_segment();
		send_op(OP_APPEND, 32'sh00010000, -32'sh00020000, COORD_MIN, 0);
		send_op(OP_EVAL, 0, 0, 0, 18'sd0);
		send_op(OP_EVAL, 0, 0, 0, 18'sd65536);
		send_op(OP_EVAL, 0, 0, 0, -18'sd131072);
		send_op(OP_EVAL, 0, 0, 0, 18'sd131071);
		send_op(OP_EVAL, 0, 0, 0, 18'sd32768);
		send_op(OP_EVAL, 0, 0, 0, 18'sd1);
		send_op(OP_EVAL, 0, 0, 0, -18'sd1);
	endtask

	// full-scale coordinates drive the sums into saturation
	task automatic test_coord_extremes();
		send_op(OP_CLEAR, 0, 0, 0, 0);
		repeat (4)
			send_op(OP_APPEND, COORD_MAX, COORD_MIN, COORD_MAX, 0);
		send_op(OP_EVAL, 0, 0, 0, 18'sd0);
		send_op(OP_EVAL, 0, 0, 0, 18'sd21845);
		send_op(OP_EVAL, 0, 0, 0, 18'sd65536);
	endtask

	// random op, or clear, fill a random count (past full at times), evaluate
	task automatic test_random_curves(input int n_items);
		int sent, n_app, n_eval;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(9) == 0) begin
				send_op(OP_W'($urandom_range(3)), rand_coord(), rand_coord(), rand_coord(),
					T_W'($urandom));
				sent++;
			end else begin
				send_op(OP_CLEAR, rand_coord(), rand_coord(), rand_coord(), rand_t());
				sent++;
				case ($urandom_range(19))
					0, 1: n_app = $urandom_range(3);
					2, 3: n_app = $urandom_range(60, 70);
					default: n_app = $urandom_range(4, 12);
				endcase
				repeat (n_app) begin
					send_op(OP_APPEND, rand_coord(), rand_coord(), rand_coord(), rand_t());
					sent++;
				end
				n_eval = $urandom_range(1, 16);
				repeat (n_eval) begin
					if ($urandom_range(7) == 0)
						send_op(OP_APPEND, rand_coord(), rand_coord(), rand_coord(), rand_t());
					else
						send_op(OP_EVAL, rand_coord(), rand_coord(), rand_coord(), rand_t());
					sent++;
				end
			end
		end
	endtask

	task automatic test_no_idle();
		calm = 1'b1;
		test_random_curves(150);
		calm = 1'b0;
	endtask

	// receiver holds off while the sender keeps offering transactions
	task automatic test_backpressure();
		send_op(OP_CLEAR, 0, 0, 0, 0);
		repeat (6)
			send_op(OP_APPEND, rand_coord(), rand_coord(), rand_coord(), rand_t());
		stall_req = 1'b1;
		repeat (14)
			send_op(OP_EVAL, 0, 0, 0, rand_t());
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = OP_CLEAR;
		point_x = '0;
		point_y = '0;
		point_z = '0;
		t_param = '0;
		n_pts = 0;
		mismatches = 0;
		calm = 1'b0;
		stall_req = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_store();
		test_single_segment();
		test_coord_extremes();
		test_no_idle();
		test_backpressure();
		test_random_curves(1100);
		in_valid <= 1'b0;
		while (due_outputs.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		if (mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
